/* hdl/cdn_pkg.sv */
// Shared types, constants and calendar functions for the calendar date normaliser.
// Used by cdn_step and calendar_date_normalizer; depends on nothing else.
package cdn_pkg;

    localparam int DAY_W   = 23;
    localparam int MONTH_W = 17;
    localparam int YEAR_W  = 18;
    localparam int YMOD_W  = 9;
    localparam int RED_W   = 18;
    localparam int STEP_W  = 4;

    localparam logic [2:0] OP_NORM    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_SUB     = 3'd2;
    localparam logic [2:0] OP_ADD_CNT = 3'd3;
    localparam logic [2:0] OP_SUB_CNT = 3'd4;

    localparam logic [YMOD_W-1:0] YMOD_LAST = 9'd399;
    localparam logic [RED_W-1:0]  RED_BASE  = 18'd400;
    localparam logic [RED_W:0]    YEAR_BIAS = 19'd65600;
    localparam logic [STEP_W-1:0] RED_STEPS = 4'd8;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MOD  = 7'b0000010,
        ST_MHI  = 7'b0000100,
        ST_MLO  = 7'b0001000,
        ST_DHI  = 7'b0010000,
        ST_DLO  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic signed [DAY_W-1:0]   d;
        logic signed [MONTH_W-1:0] m;
        logic signed [YEAR_W-1:0]  y;
        logic [YMOD_W-1:0]         ymod;
        logic [RED_W-1:0]          r;
        logic [STEP_W-1:0]         k;
    } dp_t;

    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic by4;
        by4 = (ymod[1:0] == 2'b00);
        return (ymod == '0) ||
               (by4 && (ymod != 9'd100) && (ymod != 9'd200) && (ymod != 9'd300));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] year_days(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

endpackage

/* hdl/calendar_date_normalizer.sv */
// Calendar date normaliser: forms a raw date and normalises it one step per cycle.
// It reduces the year residue, wraps the month up or down by twelve months, then runs
// the day carry by month or year steps; one word is in work at a time.
// Reset (rst_n, asynchronous, active low) empties the block; the data registers are not reset.
// Depends on cdn_pkg and cdn_step.
module calendar_date_normalizer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_day, a_month, a_year, b_day, b_month, b_year, day_count
    input  logic [2:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // out_day, out_month, out_year, a_after_b
    output logic         m_tuser   // year_saturated
);

    cdn_pkg::state_t state_reg;
    cdn_pkg::state_t state_next;
    cdn_pkg::dp_t    dp_reg;
    cdn_pkg::dp_t    dp_next;
    cdn_pkg::dp_t    step_nxt;
    logic            step_done;
    logic            after_reg;
    logic            out_valid_reg;
    logic [4:0]      out_day_reg;
    logic [3:0]      out_month_reg;
    logic [15:0]     out_year_reg;
    logic            out_after_reg;
    logic            out_sat_reg;

    logic signed [20:0] a_day;
    logic signed [15:0] a_month;
    logic signed [15:0] a_year;
    logic signed [20:0] b_day;
    logic signed [15:0] b_month;
    logic signed [15:0] b_year;
    logic signed [20:0] day_count;
    logic [2:0]         operation;

    logic signed [21:0] dc_ext;
    logic signed [21:0] cnt_abs;
    logic signed [cdn_pkg::DAY_W-1:0]   ad_ext;
    logic signed [cdn_pkg::DAY_W-1:0]   bd_ext;
    logic signed [cdn_pkg::DAY_W-1:0]   cnt_ext;
    logic signed [cdn_pkg::MONTH_W-1:0] am_ext;
    logic signed [cdn_pkg::MONTH_W-1:0] bm_ext;
    logic signed [cdn_pkg::YEAR_W-1:0]  ay_ext;
    logic signed [cdn_pkg::YEAR_W-1:0]  by_ext;
    logic signed [cdn_pkg::DAY_W-1:0]   d_raw;
    logic signed [cdn_pkg::MONTH_W-1:0] m_raw;
    logic signed [cdn_pkg::YEAR_W-1:0]  y_raw;
    logic [cdn_pkg::RED_W:0]            y_biased;
    logic                               after_raw;
    logic                               accept;
    logic                               out_free;
    logic                               y_small;
    logic                               y_big;

    assign a_day     = s_tdata[20:0];
    assign a_month   = s_tdata[36:21];
    assign a_year    = s_tdata[52:37];
    assign b_day     = s_tdata[73:53];
    assign b_month   = s_tdata[89:74];
    assign b_year    = s_tdata[105:90];
    assign day_count = s_tdata[126:106];
    assign operation = s_tuser;

    assign dc_ext  = {day_count[20], day_count};
    assign cnt_abs = dc_ext[21] ? -dc_ext : dc_ext;
    assign ad_ext  = {{2{a_day[20]}}, a_day};
    assign bd_ext  = {{2{b_day[20]}}, b_day};
    assign cnt_ext = {1'b0, cnt_abs};
    assign am_ext  = {a_month[15], a_month};
    assign bm_ext  = {b_month[15], b_month};
    assign ay_ext  = {{2{a_year[15]}}, a_year};
    assign by_ext  = {{2{b_year[15]}}, b_year};

    always_comb
    begin
        d_raw = ad_ext;
        m_raw = am_ext;
        y_raw = ay_ext;
        unique case (operation)
            cdn_pkg::OP_ADD:
            begin
                d_raw = ad_ext + bd_ext;
                m_raw = am_ext + bm_ext;
                y_raw = ay_ext + by_ext;
            end
            cdn_pkg::OP_SUB:
            begin
                d_raw = ad_ext - bd_ext;
                m_raw = am_ext - bm_ext;
                y_raw = ay_ext - by_ext;
            end
            cdn_pkg::OP_ADD_CNT:
            begin
                d_raw = ad_ext + cnt_ext;
            end
            cdn_pkg::OP_SUB_CNT:
            begin
                d_raw = ad_ext - cnt_ext;
            end
            default:
            begin
                d_raw = ad_ext;
            end
        endcase
    end

    assign y_biased = {y_raw[cdn_pkg::YEAR_W-1], y_raw} + cdn_pkg::YEAR_BIAS;

    always_comb
    begin
        if (a_year != b_year)
        begin
            after_raw = (a_year > b_year);
        end
        else if (a_month != b_month)
        begin
            after_raw = (a_month > b_month);
        end
        else
        begin
            after_raw = (a_day > b_day);
        end
    end

    cdn_step u_step
    (
        .phase (state_reg),
        .cur   (dp_reg),
        .nxt   (step_nxt),
        .done  (step_done)
    );

    assign s_tready = (state_reg == cdn_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign y_small  = (dp_reg.y < 18'sd1);
    assign y_big    = (dp_reg.y > 18'sd65535);

    always_comb
    begin
        state_next = state_reg;
        dp_next    = step_nxt;
        unique case (state_reg)
            cdn_pkg::ST_IDLE:
            begin
                dp_next = dp_reg;
                if (accept)
                begin
                    dp_next.d    = d_raw;
                    dp_next.m    = m_raw;
                    dp_next.y    = y_raw;
                    dp_next.ymod = '0;
                    dp_next.r    = y_biased[cdn_pkg::RED_W-1:0];
                    dp_next.k    = cdn_pkg::RED_STEPS;
                    state_next   = cdn_pkg::ST_MOD;
                end
            end
            cdn_pkg::ST_MOD:
            begin
                if (step_done)
                begin
                    state_next = cdn_pkg::ST_MHI;
                end
            end
            cdn_pkg::ST_MHI:
            begin
                if (step_done)
                begin
                    state_next = cdn_pkg::ST_MLO;
                end
            end
            cdn_pkg::ST_MLO:
            begin
                if (step_done)
                begin
                    state_next = cdn_pkg::ST_DHI;
                end
            end
            cdn_pkg::ST_DHI:
            begin
                if (step_done)
                begin
                    state_next = cdn_pkg::ST_DLO;
                end
            end
            cdn_pkg::ST_DLO:
            begin
                if (step_done)
                begin
                    state_next = cdn_pkg::ST_FIN;
                end
            end
            cdn_pkg::ST_FIN:
            begin
                dp_next = dp_reg;
                if (out_free)
                begin
                    state_next = cdn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                dp_next    = dp_reg;
                state_next = cdn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdn_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == cdn_pkg::ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dp_reg <= dp_next;
        if (accept)
        begin
            after_reg <= after_raw;
        end
        if ((state_reg == cdn_pkg::ST_FIN) && out_free)
        begin
            out_day_reg   <= dp_reg.d[4:0];
            out_month_reg <= dp_reg.m[3:0];
            out_after_reg <= after_reg;
            out_sat_reg   <= y_big;
            if (y_small)
            begin
                out_year_reg <= 16'd1;
            end
            else if (y_big)
            begin
                out_year_reg <= 16'hFFFF;
            end
            else
            begin
                out_year_reg <= dp_reg.y[15:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_after_reg, out_year_reg, out_month_reg, out_day_reg};
    assign m_tuser  = out_sat_reg;

    // The sequencer always starts a word with the year reduction.
    a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == cdn_pkg::ST_MOD))
        else $error("accepted word did not start the year reduction");

    // Once the day carry runs, the month has been brought into range.
    a_month_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cdn_pkg::ST_DHI) || (state_reg == cdn_pkg::ST_DLO)) |->
        ((dp_reg.m >= 17'sd1) && (dp_reg.m <= 17'sd12)))
        else $error("month out of range during day carry");

    // The tracked year residue stays below four hundred after reduction.
    a_residue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cdn_pkg::ST_MHI) || (state_reg == cdn_pkg::ST_DHI) ||
         (state_reg == cdn_pkg::ST_DLO)) |-> (dp_reg.ymod < 9'd400))
        else $error("year residue out of range");

    // A delivered word carries a valid day and month.
    a_output_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_day_reg != 5'd0) && (out_month_reg != 4'd0) &&
                      (out_month_reg <= 4'd12)))
        else $error("output date out of range");

endmodule

/* hdl/cdn_step.sv */
// Shared step unit: one compare and adjust of the working date per cycle.
// Depends on cdn_pkg; driven by the sequencer in calendar_date_normalizer.
module cdn_step
(
    input  cdn_pkg::state_t phase,
    input  cdn_pkg::dp_t    cur,
    output cdn_pkg::dp_t    nxt,
    output logic            done
);

    logic [cdn_pkg::YMOD_W-1:0]        ymod_inc;
    logic [cdn_pkg::YMOD_W-1:0]        pymod;
    logic signed [cdn_pkg::YEAR_W-1:0] y_inc;
    logic signed [cdn_pkg::YEAR_W-1:0] py;
    logic                              y_low;
    logic                              leap_cur;
    logic                              leap_py;
    logic [3:0]                        mon;
    logic [4:0]                        dim;
    logic [4:0]                        prev_dim;
    logic signed [cdn_pkg::DAY_W-1:0]  d_dim;
    logic signed [cdn_pkg::DAY_W-1:0]  d_prev;
    logic signed [cdn_pkg::DAY_W-1:0]  d_ylen;
    logic signed [cdn_pkg::DAY_W-1:0]  d_ylen_py;
    logic signed [cdn_pkg::DAY_W-1:0]  d_back_year;
    logic [cdn_pkg::RED_W:0]           red_sub;
    logic                              red_borrow;

    assign ymod_inc  = (cur.ymod == cdn_pkg::YMOD_LAST) ? '0 : cur.ymod + 9'd1;
    assign y_inc     = cur.y + 18'sd1;
    assign y_low     = (cur.y < 18'sd2);
    assign py        = y_low ? 18'sd1 : cur.y - 18'sd1;
    assign pymod     = y_low ? 9'd1 :
                       ((cur.ymod == '0) ? cdn_pkg::YMOD_LAST : cur.ymod - 9'd1);
    assign leap_cur  = cdn_pkg::is_leap(cur.ymod);
    assign leap_py   = cdn_pkg::is_leap(pymod);
    assign mon       = cur.m[3:0];
    assign dim       = cdn_pkg::month_days(mon, leap_cur);
    assign prev_dim  = cdn_pkg::month_days(mon - 4'd1, leap_cur);
    assign d_dim     = {18'd0, dim};
    assign d_prev    = {18'd0, prev_dim};
    assign d_ylen    = {14'd0, cdn_pkg::year_days(leap_cur)};
    assign d_ylen_py = {14'd0, cdn_pkg::year_days(leap_py)};
    assign d_back_year = cur.d + d_ylen_py;

    assign red_sub    = {1'b0, cur.r} - {1'b0, cdn_pkg::RED_BASE << cur.k};
    assign red_borrow = red_sub[cdn_pkg::RED_W];

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        unique case (phase)
            cdn_pkg::ST_MOD:
            begin
                if (!red_borrow)
                begin
                    nxt.r = red_sub[cdn_pkg::RED_W-1:0];
                end
                if (cur.k == '0)
                begin
                    done     = 1'b1;
                    nxt.ymod = red_borrow ? cur.r[cdn_pkg::YMOD_W-1:0]
                                          : red_sub[cdn_pkg::YMOD_W-1:0];
                end
                else
                begin
                    nxt.k = cur.k - 4'd1;
                end
            end
            cdn_pkg::ST_MHI:
            begin
                if (cur.m > 17'sd12)
                begin
                    nxt.m    = cur.m - 17'sd12;
                    nxt.y    = y_inc;
                    nxt.ymod = ymod_inc;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            cdn_pkg::ST_MLO:
            begin
                if (cur.m < 17'sd1)
                begin
                    nxt.m    = cur.m + 17'sd12;
                    nxt.y    = py;
                    nxt.ymod = pymod;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            cdn_pkg::ST_DHI:
            begin
                if (cur.d > d_dim)
                begin
                    if ((mon == 4'd1) && (cur.d > d_ylen))
                    begin
                        nxt.d    = cur.d - d_ylen;
                        nxt.y    = y_inc;
                        nxt.ymod = ymod_inc;
                    end
                    else
                    begin
                        nxt.d = cur.d - d_dim;
                        if (mon == 4'd12)
                        begin
                            nxt.m    = 17'sd1;
                            nxt.y    = y_inc;
                            nxt.ymod = ymod_inc;
                        end
                        else
                        begin
                            nxt.m = cur.m + 17'sd1;
                        end
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            cdn_pkg::ST_DLO:
            begin
                if (cur.d <= 23'sd0)
                begin
                    if ((mon == 4'd1) && (d_back_year <= 23'sd0))
                    begin
                        nxt.d    = d_back_year;
                        nxt.y    = py;
                        nxt.ymod = pymod;
                    end
                    else if (mon == 4'd1)
                    begin
                        nxt.m    = 17'sd12;
                        nxt.y    = py;
                        nxt.ymod = pymod;
                        nxt.d    = cur.d + 23'sd31;
                    end
                    else
                    begin
                        nxt.m = cur.m - 17'sd1;
                        nxt.d = cur.d + d_prev;
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

endmodule
